@@ rtl/mhh_pkg.sv @@
// ----------------------------------------------------------------------------
// mhh_pkg: shared types and constants of the multilevel heater controller
// Request and result layouts, configuration set, level and command codes,
// and the level to duty / PWM tables.
// ----------------------------------------------------------------------------
package mhh_pkg;

    // Heater level codes.
    localparam logic [2:0] LVL_UNKNOWN = 3'd0;
    localparam logic [2:0] LVL_OFF     = 3'd1;
    localparam logic [2:0] LVL_LOW     = 3'd2;
    localparam logic [2:0] LVL_MED     = 3'd3;
    localparam logic [2:0] LVL_HIGH    = 3'd4;

    // Command codes carried in func.
    localparam logic [1:0] FUNC_UPDATE   = 2'd0;
    localparam logic [1:0] FUNC_SHUTDOWN = 2'd1;
    localparam logic [1:0] FUNC_STATS    = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_HIGH_BELOW = 3'd0;
    localparam logic [2:0] REG_MED_BELOW  = 3'd1;
    localparam logic [2:0] REG_LOW_BELOW  = 3'd2;
    localparam logic [2:0] REG_HOLD_BELOW = 3'd3;
    localparam logic [2:0] REG_OFF_AT     = 3'd4;
    localparam logic [2:0] REG_JUMP_LIMIT = 3'd5;

    localparam int unsigned ADDR_W = 5;

    // Reset values of the configuration registers, 1/16 degree C.
    localparam logic signed [11:0] RST_HIGH_BELOW = -12'sd32;
    localparam logic signed [11:0] RST_MED_BELOW  = 12'sd0;
    localparam logic signed [11:0] RST_LOW_BELOW  = 12'sd48;
    localparam logic signed [11:0] RST_HOLD_BELOW = 12'sd96;
    localparam logic signed [11:0] RST_OFF_AT     = 12'sd128;
    localparam logic [11:0]        RST_JUMP_LIMIT = 12'd160;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [11:0] temperature;
        logic               sensor_ok;
        logic [31:0]        now_ms;
    } t_req;

    typedef struct packed {
        logic [2:0]  level;
        logic [6:0]  duty_pct;
        logic [7:0]  pwm_value;
        logic        boost_enable;
        logic        level_changed;
        logic        jump_warning;
        logic        status;
        logic [31:0] cycle_count;
        logic [31:0] change_count;
        logic [31:0] heating_time_ms;
    } t_res;

    typedef struct packed {
        logic signed [11:0] high_below;
        logic signed [11:0] med_below;
        logic signed [11:0] low_below;
        logic signed [11:0] hold_below;
        logic signed [11:0] off_at;
        logic [11:0]        jump_limit;
    } t_cfg;

    function automatic logic [6:0] duty_of(input logic [2:0] lvl);
        logic [6:0] d;
        case (lvl)
            LVL_LOW:  d = 7'd25;
            LVL_MED:  d = 7'd50;
            LVL_HIGH: d = 7'd75;
            default:  d = 7'd0;
        endcase
        return d;
    endfunction

    // duty * 255 / 100, truncated.
    function automatic logic [7:0] pwm_of(input logic [2:0] lvl);
        logic [7:0] p;
        case (lvl)
            LVL_LOW:  p = 8'd63;
            LVL_MED:  p = 8'd127;
            LVL_HIGH: p = 8'd191;
            default:  p = 8'd0;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/mhh_cfg.sv @@
// ----------------------------------------------------------------------------
// mhh_cfg: configuration register file
// APB-style write and read access to the five thresholds and the jump limit.
// ----------------------------------------------------------------------------
module mhh_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mhh_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output mhh_pkg::t_cfg              o_cfg
);
    import mhh_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;
    logic [11:0] w_rd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_below <= RST_HIGH_BELOW;
            r_cfg.med_below  <= RST_MED_BELOW;
            r_cfg.low_below  <= RST_LOW_BELOW;
            r_cfg.hold_below <= RST_HOLD_BELOW;
            r_cfg.off_at     <= RST_OFF_AT;
            r_cfg.jump_limit <= RST_JUMP_LIMIT;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_HIGH_BELOW: r_cfg.high_below <= pwdata[11:0];
                REG_MED_BELOW:  r_cfg.med_below  <= pwdata[11:0];
                REG_LOW_BELOW:  r_cfg.low_below  <= pwdata[11:0];
                REG_HOLD_BELOW: r_cfg.hold_below <= pwdata[11:0];
                REG_OFF_AT:     r_cfg.off_at     <= pwdata[11:0];
                REG_JUMP_LIMIT: r_cfg.jump_limit <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_HIGH_BELOW: w_rd = r_cfg.high_below;
            REG_MED_BELOW:  w_rd = r_cfg.med_below;
            REG_LOW_BELOW:  w_rd = r_cfg.low_below;
            REG_HOLD_BELOW: w_rd = r_cfg.hold_below;
            REG_OFF_AT:     w_rd = r_cfg.off_at;
            REG_JUMP_LIMIT: w_rd = r_cfg.jump_limit;
            default:        w_rd = 12'd0;
        endcase
    end

    assign prdata = {20'd0, w_rd};
    assign o_cfg  = r_cfg;

endmodule

@@ rtl/mhh_step.sv @@
// ----------------------------------------------------------------------------
// mhh_step: controller state and per-request update
// Holds the heater level, boost flag and statistics, and forms the result
// of the request presented on i_req when i_fire is high.
// ----------------------------------------------------------------------------
module mhh_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  mhh_pkg::t_req i_req,
    input  mhh_pkg::t_cfg i_cfg,
    output mhh_pkg::t_res o_res
);
    import mhh_pkg::*;

    logic [2:0]         r_level,     n_level;
    logic               r_boost,     n_boost;
    logic               r_started,   n_started;
    logic signed [11:0] r_last_temp, n_last_temp;
    logic [31:0]        r_last_time, n_last_time;
    logic [31:0]        r_cycles,    n_cycles;
    logic [31:0]        r_changes,   n_changes;
    logic [31:0]        r_heat,      n_heat;

    logic [2:0]         w_chosen;
    logic signed [12:0] w_diff;
    logic [12:0]        w_diff_u;
    logic [12:0]        w_mag;
    logic               w_jump;
    logic               w_changed;
    logic               w_status;

    // Threshold ladder, tested in fixed order whatever the register values.
    always_comb begin
        if (i_req.temperature < i_cfg.high_below) begin
            w_chosen = LVL_HIGH;
        end else if (i_req.temperature < i_cfg.med_below) begin
            w_chosen = LVL_MED;
        end else if (i_req.temperature < i_cfg.low_below) begin
            w_chosen = LVL_LOW;
        end else if (i_req.temperature < i_cfg.hold_below) begin
            w_chosen = r_level;
        end else if (i_req.temperature >= i_cfg.off_at) begin
            w_chosen = LVL_OFF;
        end else if (r_level == LVL_HIGH || r_level == LVL_MED) begin
            w_chosen = LVL_LOW;
        end else begin
            w_chosen = r_level;
        end
    end

    assign w_diff   = {i_req.temperature[11], i_req.temperature}
                    - {r_last_temp[11], r_last_temp};
    assign w_diff_u = w_diff;
    assign w_mag    = w_diff_u[12] ? (~w_diff_u + 13'd1) : w_diff_u;

    always_comb begin
        n_level     = r_level;
        n_boost     = r_boost;
        n_started   = r_started;
        n_last_temp = r_last_temp;
        n_last_time = r_last_time;
        n_cycles    = r_cycles;
        n_changes   = r_changes;
        n_heat      = r_heat;
        w_jump      = 1'b0;
        w_changed   = 1'b0;
        w_status    = 1'b0;
        case (i_req.func)
            FUNC_UPDATE: begin
                if (!i_req.sensor_ok) begin
                    w_status = 1'b1;
                end else if (!r_started) begin
                    // First good reading only initializes.
                    n_level     = w_chosen;
                    n_boost     = (duty_of(w_chosen) != 7'd0);
                    n_started   = 1'b1;
                    n_last_temp = i_req.temperature;
                    n_last_time = i_req.now_ms;
                end else begin
                    w_jump      = (w_mag > {1'b0, i_cfg.jump_limit});
                    n_last_temp = i_req.temperature;
                    if (w_chosen != r_level) begin
                        n_level   = w_chosen;
                        n_changes = r_changes + 32'd1;
                        w_changed = 1'b1;
                        n_boost   = (duty_of(w_chosen) != 7'd0);
                        if (duty_of(w_chosen) != 7'd0 && r_level == LVL_OFF) begin
                            n_cycles = r_cycles + 32'd1;
                        end
                    end
                    if (n_level != LVL_OFF) begin
                        n_heat = r_heat + (i_req.now_ms - r_last_time);
                    end
                    n_last_time = i_req.now_ms;
                end
            end
            FUNC_SHUTDOWN: begin
                n_level = LVL_OFF;
                n_boost = 1'b0;
            end
            FUNC_STATS: begin
                n_cycles  = 32'd0;
                n_changes = 32'd0;
                n_heat    = 32'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LVL_UNKNOWN;
            r_boost     <= 1'b0;
            r_started   <= 1'b0;
            r_last_temp <= 12'sd0;
            r_last_time <= 32'd0;
            r_cycles    <= 32'd0;
            r_changes   <= 32'd0;
            r_heat      <= 32'd0;
        end else if (i_fire) begin
            r_level     <= n_level;
            r_boost     <= n_boost;
            r_started   <= n_started;
            r_last_temp <= n_last_temp;
            r_last_time <= n_last_time;
            r_cycles    <= n_cycles;
            r_changes   <= n_changes;
            r_heat      <= n_heat;
        end
    end

    always_comb begin
        o_res.level           = n_level;
        o_res.duty_pct        = duty_of(n_level);
        o_res.pwm_value       = pwm_of(n_level);
        o_res.boost_enable    = n_boost;
        o_res.level_changed   = w_changed;
        o_res.jump_warning    = w_jump;
        o_res.status          = w_status;
        o_res.cycle_count     = n_cycles;
        o_res.change_count    = n_changes;
        o_res.heating_time_ms = n_heat;
    end

    // The boost flag always agrees with a level that has a nonzero duty.
    a_boost_matches_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boost == (r_level == LVL_LOW || r_level == LVL_MED || r_level == LVL_HIGH))
        else $error("boost flag disagrees with heater level");

    a_shutdown_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_req.func == FUNC_SHUTDOWN |=> r_level == LVL_OFF && !r_boost)
        else $error("shutdown did not turn the heater off");

    a_stats_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_req.func == FUNC_STATS |=>
            r_cycles == 32'd0 && r_changes == 32'd0 && r_heat == 32'd0)
        else $error("statistics reset did not clear the counters");

    // A failed reading leaves the state untouched; the level, last time and heating time are checked.
    a_sensor_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_req.func == FUNC_UPDATE && !i_req.sensor_ok |=>
            $stable(r_level) && $stable(r_last_time) && $stable(r_heat))
        else $error("failed reading changed the state");

endmodule

@@ rtl/multilevel_heater_hysteresis_core.sv @@
// ----------------------------------------------------------------------------
// multilevel_heater_hysteresis_core: multilevel battery heater controller
// Temperature hysteresis on a four-level heater with statistics, behind a
// registered request stage and a registered result stage.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------
//  request  | in        | i_in_valid / o_in_stall | i_in_req (t_req)
//  result   | out       | o_out_valid/ i_out_stall| o_out_res (t_res)
//  config   | in        | psel/penable/pready     | paddr, pwdata, prdata
//
// One request is accepted per clock cycle while o_in_stall is low. It is held
// in the request register, and its result is then loaded into the result
// register, from which it is taken. The level decision and all counter
// updates are one pass of compare and 32-bit add logic between those two
// registers.
// Reset (i_rst_n low at a clock edge) empties both stages and returns the
// heater state, statistics and thresholds to their reset values.
// A stall on the result side backs up into the request register; o_in_stall
// rises only when both stages hold a request.
// ----------------------------------------------------------------------------
module multilevel_heater_hysteresis_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  mhh_pkg::t_req              i_in_req,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output mhh_pkg::t_res              o_out_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mhh_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import mhh_pkg::*;

    t_cfg w_cfg;
    t_res w_res;

    // Request register.
    logic r_in_valid;
    t_req r_in;
    // Result register.
    logic r_out_valid;
    t_res r_out;

    logic w_advance;
    logic w_accept;

    // The held request moves into the result register whenever that
    // register is empty or its result is being taken in this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    mhh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The controller state commits at the same edge the result is captured.
    mhh_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_req   (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule
